// ===== rtl/swmf_pkg.sv =====
// Shared types and constants for the sliding window median filter.
// No dependencies.
`default_nettype none

package swmf_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    typedef logic [PIX_W-1:0]     pixel_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [COL_OUT_W-1:0] col_out_t;

endpackage

`default_nettype wire

// ===== rtl/swmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swmf_median.sv =====
// Rank-count median selector over N pixels, single combinational pass.
// Depends on swmf_pkg.
`default_nettype none

module swmf_median import swmf_pkg::*; #(
    parameter int N = 25
) (
    input  wire logic [N*PIX_W-1:0] window,
    output pixel_t                  median
);

    localparam int K = N / 2;

    pixel_t         v  [N];
    logic   [N-1:0] lt [N];
    logic   [N-1:0] le [N];
    logic   [N-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            v[i] = window[i*PIX_W +: PIX_W];
        end
    end

    // element i is the median when at most K values are below it and more than K
    // are at or below it; tied hits carry equal values, so OR-ing them is exact
    always_comb
    begin
        median = '0;
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                lt[i][j] = v[j] <  v[i];
                le[i][j] = v[j] <= v[i];
            end
            hit[i] = ($countones(lt[i]) <= K) && ($countones(le[i]) > K);
            if (hit[i])
            begin
                median = median | v[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_filter_unit.sv =====
// Top level of the sliding window median filter.
// Depends on swmf_pkg, swmf_ram and swmf_median.
//
// Pixels enter in raster order, one per clock while pixel_stall is low; the result for
// an interior pixel is presented after the line store read at the accept edge, the
// window shift and the median register. The line store is one RAM of MAX_WIDTH words,
// each holding the WINDOW-1 previous rows of a column, with a bypass for back-to-back
// hits on the same column. The median comes from a rank-count selector across the
// WINDOW x WINDOW window registers in one pass, so the rate is one pixel per clock
// whenever the result side is not stalled. Borders produce no item. The line store
// needs no clearing after reset. The user must write image_width and image_height
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module sliding_window_median_filter_unit import swmf_pkg::*; #(
    parameter int WINDOW    = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire pixel_t                pixel,
    input  wire logic                  frame_start,

    output logic                       median_valid,
    input  wire logic                  median_stall,
    output pixel_t                     median_value,
    output row_t                       center_row,
    output col_out_t                   center_col,
    output logic                       last
);

    localparam int H    = WINDOW / 2;
    localparam int NL   = WINDOW - 1;
    localparam int N    = WINDOW * WINDOW;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = CW + 1;
    localparam int WCMP = (EW > IMG_W_W) ? EW : IMG_W_W;
    localparam int CCW  = (CW > COL_OUT_W) ? CW : COL_OUT_W;
    localparam int LW   = NL * PIX_W;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [CW-1:0]      col_count_reg;
    row_t               row_count_reg;

    logic               en;
    logic               accept;

    logic [WCMP-1:0]    iw_x;
    logic [EW-1:0]      w_eff;
    row_t               h_eff;
    logic [CW-1:0]      c_cur;
    row_t               r_cur;
    logic               col_wrap;
    logic               row_wrap;
    logic [CW-1:0]      col_next;
    row_t               row_next;
    logic               emit_cur;
    logic               last_cur;
    logic [CCW-1:0]     ccol_x;

    logic               s1_valid_reg;
    pixel_t             s1_pixel_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    row_t               s1_crow_reg;
    col_out_t           s1_ccol_reg;
    logic               byp_reg;
    logic [LW-1:0]      byp_data_reg;

    logic               s2_valid_reg;
    logic               s2_emit_reg;
    logic               s2_last_reg;
    row_t               s2_crow_reg;
    col_out_t           s2_ccol_reg;

    logic [LW-1:0]      ram_q;
    logic [LW-1:0]      lines;
    logic [LW-1:0]      wr_data;
    logic               wr_en;
    pixel_t             col [WINDOW];
    pixel_t             win_reg [WINDOW][WINDOW];
    logic [N*PIX_W-1:0] win_flat;
    pixel_t             median_next;

    logic               out_valid_reg;
    pixel_t             median_value_reg;
    row_t               center_row_reg;
    col_out_t           center_col_reg;
    logic               last_reg;

    // handshake
    assign en          = !(out_valid_reg && median_stall);
    assign pixel_stall = out_valid_reg && median_stall;
    assign accept      = pixel_valid && !pixel_stall;
    assign cfg_ready   = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective frame size
    assign iw_x = WCMP'(width_reg);

    always_comb
    begin
        if (iw_x == '0)
        begin
            w_eff = EW'(1);
        end
        else if (iw_x > WCMP'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = EW'(iw_x);
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    // position of the incoming pixel
    always_comb
    begin
        c_cur = col_count_reg;
        r_cur = row_count_reg;
        if (frame_start)
        begin
            c_cur = '0;
            r_cur = '0;
        end
        if ({1'b0, c_cur} >= w_eff)
        begin
            c_cur = '0;
        end
        if (r_cur >= h_eff)
        begin
            r_cur = '0;
        end
        col_wrap = ({1'b0, c_cur} + EW'(1)) >= w_eff;
        row_wrap = ({1'b0, r_cur} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};
        col_next = col_wrap ? '0 : c_cur + CW'(1);
        row_next = col_wrap ? (row_wrap ? '0 : r_cur + ROW_W'(1)) : r_cur;
        emit_cur = (r_cur >= ROW_W'(2 * H)) && ({1'b0, c_cur} >= EW'(2 * H));
        last_cur = (r_cur == h_eff - ROW_W'(1)) && ({1'b0, c_cur} == w_eff - EW'(1));
        ccol_x   = CCW'(c_cur) - CCW'(H);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_next;
            row_count_reg <= row_next;
        end
    end

    // stage 1: line store read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            byp_reg      <= s1_valid_reg && (s1_col_reg == c_cur);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            byp_data_reg <= wr_data;
        end
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= c_cur;
            s1_emit_reg  <= emit_cur;
            s1_last_reg  <= last_cur;
            s1_crow_reg  <= r_cur - ROW_W'(H);
            s1_ccol_reg  <= ccol_x[COL_OUT_W-1:0];
        end
    end

    swmf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_col_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (c_cur),
        .rdata (ram_q)
    );

    // new column, oldest row first; line i sits at bits [8i +: 8]
    assign lines   = byp_reg ? byp_data_reg : ram_q;
    assign wr_data = {s1_pixel_reg, lines[LW-1:PIX_W]};
    assign wr_en   = en && s1_valid_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            col[i] = lines[i*PIX_W +: PIX_W];
        end
        col[NL] = s1_pixel_reg;
    end

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                for (int j = 0; j < WINDOW; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                for (int j = 0; j < WINDOW - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][WINDOW-1] <= col[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            s2_emit_reg <= s1_emit_reg;
            s2_last_reg <= s1_last_reg;
            s2_crow_reg <= s1_crow_reg;
            s2_ccol_reg <= s1_ccol_reg;
        end
    end

    // stage 2: median of the window into the result register
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                win_flat[(i*WINDOW + j)*PIX_W +: PIX_W] = win_reg[i][j];
            end
        end
    end

    swmf_median #(
        .N (N)
    ) u_median (
        .window (win_flat),
        .median (median_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s2_valid_reg && s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg && s2_emit_reg)
        begin
            median_value_reg <= median_next;
            center_row_reg   <= s2_crow_reg;
            center_col_reg   <= s2_ccol_reg;
            last_reg         <= s2_last_reg;
        end
    end

    assign median_valid = out_valid_reg;
    assign median_value = median_value_reg;
    assign center_row   = center_row_reg;
    assign center_col   = center_col_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
